[hw/rtl/lcsc_pkg.sv]
// Shared types, widths and codes for the load cell sample conditioner.
// No dependencies; every other file of the block but lcsc_ram uses this package.
package lcsc_pkg;

    // default sizing handed to the top level
    localparam int RING_SIZE_DEF = 16;

    // converter word and sample widths
    localparam int SAMPLE_BITS = 24;
    localparam int SMP_W       = 25;
    localparam int TARE_W      = 24;

    // calibration and weight widths
    localparam int RAW_W       = 25;
    localparam int WGT_W       = 32;
    localparam int DEPTH_CFG_W = 5;
    localparam int THR_W       = 31;

    // datapath widths
    localparam int DIFFR_W   = RAW_W + 1;          // mean - min_raw
    localparam int SPAN_W    = WGT_W + 1;          // max_weight - min_weight
    localparam int PROD_W    = DIFFR_W + SPAN_W;   // exact product
    localparam int DEN_W     = RAW_W + 1;          // max_raw - min_raw
    localparam int MUL_SPLIT = 16;                 // low half of the span operand
    localparam int MUL_B_W   = SPAN_W - MUL_SPLIT; // operand width of one partial product
    localparam int PART_W    = DIFFR_W + MUL_B_W;  // partial product width
    localparam int WIDE_W    = PROD_W + 1;         // min_weight + quotient
    localparam int CHG_W     = WGT_W + 1;          // weight change

    // configuration port
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WEIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RAW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RAW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARE        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd6;

    // divider operand select
    localparam logic DIV_MEAN   = 1'b0;
    localparam logic DIV_WEIGHT = 1'b1;

    // input and output beats
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] raw_sample;
        logic                   timed_out;
    } in_beat_t;

    typedef struct packed {
        logic signed [WGT_W-1:0] weight;
        logic                    notify;
        logic                    read_error;
    } out_beat_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic update;
        logic div_start;
        logic div_sel;
        logic take_mean;
        logic mul_lo;
        logic mul_hi;
        logic take_q;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic timed_out;
        logic div_done;
        logic out_busy;
    } sts_t;

endpackage

[hw/rtl/lcsc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lcsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/lcsc_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on lcsc_pkg for operand widths.
module lcsc_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [lcsc_pkg::PROD_W-1:0] num,
    input  logic signed [lcsc_pkg::DEN_W-1:0]  den,
    output logic                               done,
    output logic signed [lcsc_pkg::PROD_W-1:0] quo
);

    localparam int NW    = lcsc_pkg::PROD_W;
    localparam int DW    = lcsc_pkg::DEN_W;
    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    a_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    b_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [NW-1:0] num_mag;
    logic [DW-1:0] den_mag;
    logic [DW:0]   shifted;
    logic          ge;
    logic [DW:0]   diff;
    logic [DW-1:0] rem_next;
    logic [NW-1:0] a_next;

    // operand magnitudes
    assign num_mag = num[NW-1] ? NW'(-num) : NW'(num);
    assign den_mag = den[DW-1] ? DW'(-den) : DW'(den);

    // one restoring step
    always_comb
    begin
        shifted  = {rem_reg, a_reg[NW-1]};
        ge       = shifted >= {1'b0, b_reg};
        diff     = shifted - {1'b0, b_reg};
        rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];
        a_next   = {a_reg[NW-2:0], ge};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // operand and partial result registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= num_mag;
            rem_reg <= '0;
            b_reg   <= den_mag;
            neg_reg <= num[NW-1] ^ den[DW-1];
        end
        else if (busy_reg)
        begin
            a_reg   <= a_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed(a_reg) : $signed(a_reg);

endmodule

[hw/rtl/lcsc_datapath.sv]
// Datapath: configuration registers, sample ring, running sum, multiply,
// divider and output register. Depends on lcsc_pkg, lcsc_ram, lcsc_div.
module lcsc_datapath #(
    parameter int RING_SIZE = lcsc_pkg::RING_SIZE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lcsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lcsc_pkg::CFG_W-1:0]        cfg_data,
    input  lcsc_pkg::in_beat_t                in_data,
    output lcsc_pkg::out_beat_t               out_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    input  lcsc_pkg::cmd_t                    cmd,
    output lcsc_pkg::sts_t                    sts
);

    localparam int AW    = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
    localparam int DPW   = $clog2(RING_SIZE + 1);
    localparam int SUM_W = lcsc_pkg::SMP_W + $clog2(RING_SIZE);
    localparam int SMP_W = lcsc_pkg::SMP_W;
    localparam int PW    = lcsc_pkg::PROD_W;
    localparam int WW    = lcsc_pkg::WIDE_W;
    localparam int GW    = lcsc_pkg::WGT_W;
    localparam int CW    = lcsc_pkg::CHG_W;
    localparam int SPL   = lcsc_pkg::MUL_SPLIT;

    // configuration registers
    logic signed [GW-1:0]                       min_w_reg;
    logic signed [GW-1:0]                       max_w_reg;
    logic signed [lcsc_pkg::RAW_W-1:0]          min_raw_reg;
    logic signed [lcsc_pkg::RAW_W-1:0]          max_raw_reg;
    logic signed [lcsc_pkg::TARE_W-1:0]         tare_reg;
    logic [lcsc_pkg::DEPTH_CFG_W-1:0]           depth_cfg_reg;
    logic [lcsc_pkg::THR_W-1:0]                 thr_reg;

    // ring state
    logic [RING_SIZE-1:0]      valid_reg;
    logic [AW-1:0]             pos_reg;
    logic [AW-1:0]             pos_cur_reg;
    logic signed [SUM_W-1:0]   sum_reg;

    // per-item working registers
    logic signed [SMP_W-1:0]   s_reg;
    logic                      timed_reg;
    logic signed [SMP_W-1:0]   mean_reg;
    logic signed [PW-1:0]      prod_reg;
    logic signed [GW-1:0]      w_reg;
    logic signed [GW-1:0]      cached_reg;
    logic signed [GW-1:0]      last_reg;
    lcsc_pkg::out_beat_t       out_reg;
    logic                      out_valid_reg;

    logic [DPW-1:0]            depth;
    logic [31:0]               fd32;
    logic [AW-1:0]             pos_eff;
    logic [31:0]               pos_inc;
    logic [AW-1:0]             pos_next;
    logic signed [SMP_W-1:0]   s_next;
    logic [SMP_W-1:0]          ram_rdata;
    logic signed [SMP_W-1:0]   old_smp;
    logic signed [SUM_W-1:0]   sum_next;

    logic signed [PW-1:0]                  div_num;
    logic signed [lcsc_pkg::DEN_W-1:0]     div_den;
    logic                                  div_done;
    logic signed [PW-1:0]                  div_quo;
    logic                                  zero_den;

    logic signed [lcsc_pkg::DIFFR_W-1:0]   mul_a;
    logic signed [lcsc_pkg::SPAN_W-1:0]    span;
    logic signed [lcsc_pkg::MUL_B_W-1:0]   mul_b;
    logic signed [lcsc_pkg::PART_W-1:0]    part;

    logic signed [WW-1:0]      w_wide;
    logic signed [GW-1:0]      w_next;
    logic signed [CW-1:0]      chg;
    logic [CW-1:0]             chg_abs;
    logic                      notify_next;

    // active depth, clamped to 1..RING_SIZE
    always_comb
    begin
        fd32 = 32'(depth_cfg_reg);
        if (fd32 == 32'd0)
        begin
            fd32 = 32'd1;
        end
        else if (fd32 > 32'(RING_SIZE))
        begin
            fd32 = 32'(RING_SIZE);
        end
        depth = fd32[DPW-1:0];
    end

    // ring position and sample
    assign pos_eff  = (32'(pos_reg) >= 32'(depth)) ? '0 : pos_reg;
    assign pos_inc  = 32'(pos_cur_reg) + 32'd1;
    assign pos_next = (pos_inc >= 32'(depth)) ? '0 : pos_inc[AW-1:0];
    assign s_next   = $signed({in_data.raw_sample[lcsc_pkg::SAMPLE_BITS-1], in_data.raw_sample})
                    - $signed({tare_reg[lcsc_pkg::TARE_W-1], tare_reg});
    assign old_smp  = valid_reg[pos_cur_reg] ? $signed(ram_rdata) : '0;
    assign sum_next = sum_reg + SUM_W'(s_reg) - SUM_W'(old_smp);

    lcsc_ram #(
        .WIDTH (SMP_W),
        .DEPTH (RING_SIZE),
        .AW    (AW)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.update),
        .waddr (pos_cur_reg),
        .wdata (s_reg),
        .raddr (pos_eff),
        .rdata (ram_rdata)
    );

    // shared divider: mean first, then the calibrated weight
    assign zero_den = (max_raw_reg == min_raw_reg);
    assign div_num  = (cmd.div_sel == lcsc_pkg::DIV_MEAN) ? PW'(sum_reg) : prod_reg;
    assign div_den  = (cmd.div_sel == lcsc_pkg::DIV_MEAN)
                    ? $signed(lcsc_pkg::DEN_W'(depth))
                    : lcsc_pkg::DEN_W'(max_raw_reg) - lcsc_pkg::DEN_W'(min_raw_reg);

    lcsc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // one shared multiplier, span operand taken in two halves
    assign mul_a = lcsc_pkg::DIFFR_W'(mean_reg) - lcsc_pkg::DIFFR_W'(min_raw_reg);
    assign span  = lcsc_pkg::SPAN_W'(max_w_reg) - lcsc_pkg::SPAN_W'(min_w_reg);
    assign mul_b = cmd.mul_hi ? $signed(span[lcsc_pkg::SPAN_W-1:SPL])
                              : $signed({1'b0, span[SPL-1:0]});
    assign part  = mul_a * mul_b;

    // offset add and saturation
    always_comb
    begin
        w_wide = WW'(min_w_reg) + WW'(div_quo);
        if (w_wide > WW'(32'sh7FFF_FFFF))
        begin
            w_next = 32'sh7FFF_FFFF;
        end
        else if (w_wide < WW'(32'sh8000_0000))
        begin
            w_next = 32'sh8000_0000;
        end
        else
        begin
            w_next = w_wide[GW-1:0];
        end
    end

    // change against the last notified weight
    assign chg         = CW'(w_reg) - CW'(last_reg);
    assign chg_abs     = chg[CW-1] ? CW'(-chg) : CW'(chg);
    assign notify_next = !timed_reg && (chg_abs > CW'(thr_reg));

    // configuration and ring control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_w_reg     <= '0;
            max_w_reg     <= 32'sd256000;
            min_raw_reg   <= '0;
            max_raw_reg   <= 25'sd8388607;
            tare_reg      <= '0;
            depth_cfg_reg <= 5'd1;
            thr_reg       <= 31'd256;
            valid_reg     <= '0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            cached_reg    <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lcsc_pkg::CFG_MIN_WEIGHT: min_w_reg   <= $signed(cfg_data);
                    lcsc_pkg::CFG_MAX_WEIGHT: max_w_reg   <= $signed(cfg_data);
                    lcsc_pkg::CFG_MIN_RAW:    min_raw_reg <= $signed(cfg_data[lcsc_pkg::RAW_W-1:0]);
                    lcsc_pkg::CFG_MAX_RAW:    max_raw_reg <= $signed(cfg_data[lcsc_pkg::RAW_W-1:0]);
                    lcsc_pkg::CFG_TARE:       tare_reg    <= $signed(cfg_data[lcsc_pkg::TARE_W-1:0]);
                    lcsc_pkg::CFG_DEPTH:
                    begin
                        depth_cfg_reg <= cfg_data[lcsc_pkg::DEPTH_CFG_W-1:0];
                        valid_reg     <= '0;
                        pos_reg       <= '0;
                        sum_reg       <= '0;
                    end
                    lcsc_pkg::CFG_THRESHOLD:  thr_reg <= cfg_data[lcsc_pkg::THR_W-1:0];
                    default:                  ;
                endcase
            end
            // sample enters the ring
            if (cmd.update)
            begin
                valid_reg[pos_cur_reg] <= 1'b1;
                pos_reg                <= pos_next;
                sum_reg                <= sum_next;
            end
            // result beat
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                if (!timed_reg)
                begin
                    cached_reg <= w_reg;
                    if (notify_next)
                    begin
                        last_reg <= w_reg;
                    end
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            s_reg       <= s_next;
            timed_reg   <= in_data.timed_out;
            pos_cur_reg <= pos_eff;
        end
        if (cmd.take_mean)
        begin
            mean_reg <= div_quo[SMP_W-1:0];
        end
        if (cmd.mul_lo)
        begin
            prod_reg <= PW'(part);
        end
        else if (cmd.mul_hi)
        begin
            prod_reg <= prod_reg + (PW'(part) <<< SPL);
        end
        if (cmd.take_q)
        begin
            w_reg <= zero_den ? '0 : w_next;
        end
        if (cmd.emit)
        begin
            out_reg.weight     <= timed_reg ? cached_reg : w_reg;
            out_reg.notify     <= notify_next;
            out_reg.read_error <= timed_reg;
        end
    end

    assign out_data      = out_reg;
    assign out_valid     = out_valid_reg;
    assign sts.timed_out = timed_reg;
    assign sts.div_done  = div_done;
    assign sts.out_busy  = out_valid_reg && !out_ready;

`ifndef SYNTHESIS
    // a reported change never comes from a suppressed item
    a_notify_not_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.notify |-> !out_reg.read_error)
        else $error("notify raised on a timed-out beat");

    // a reported weight is the one held as last notified
    a_notify_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.notify |-> last_reg == out_reg.weight)
        else $error("last notified weight does not match reported beat");

    // the ring position stays inside the active depth
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) < 32'(depth))
        else $error("ring position beyond active depth");
`endif

endmodule

[hw/rtl/lcsc_ctrl.sv]
// Controller: sequences one item through the ring update, both divisions,
// the two-step multiply and the output register. Depends on lcsc_pkg.
module lcsc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_timed_out,
    output logic            in_ready,
    input  lcsc_pkg::sts_t  sts,
    output lcsc_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_UPD  = 4'd1;
    localparam logic [3:0] S_D1S  = 4'd2;
    localparam logic [3:0] S_D1W  = 4'd3;
    localparam logic [3:0] S_MUL0 = 4'd4;
    localparam logic [3:0] S_MUL1 = 4'd5;
    localparam logic [3:0] S_D2S  = 4'd6;
    localparam logic [3:0] S_D2W  = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = in_timed_out ? S_EMIT : S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_D1S;
            end
            S_D1S:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = lcsc_pkg::DIV_MEAN;
                state_next    = S_D1W;
            end
            S_D1W:
            begin
                if (sts.div_done)
                begin
                    cmd.take_mean = 1'b1;
                    state_next    = S_MUL0;
                end
            end
            S_MUL0:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_D2S;
            end
            S_D2S:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = lcsc_pkg::DIV_WEIGHT;
                state_next    = S_D2W;
            end
            S_D2W:
            begin
                cmd.div_sel = lcsc_pkg::DIV_WEIGHT;
                if (sts.div_done)
                begin
                    cmd.take_q = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

[hw/rtl/load_cell_sample_conditioner.sv]
// Top level of the load cell sample conditioner: controller plus datapath.
// Depends on lcsc_pkg, lcsc_ctrl and lcsc_datapath.
//
// Each input beat carries one converter word; the block tares it, keeps a
// running sum over a ring of up to RING_SIZE samples, divides for the mean,
// maps the mean through the two calibration points and saturates to 32 bits,
// then flags a notification when the weight moved more than the threshold.
// One item at a time: a sample goes from acceptance to its result beat
// through the ring update, the mean division, two multiply steps, the
// weight division and the output register, waiting before the output
// while it stalls; the shared divider yields one quotient bit per cycle. A
// timed-out beat goes straight to the output register and changes nothing.
// The next item is taken while the previous result waits in the output
// register. Configuration writes are to be made only while idle; the block
// itself does not enforce this. Writing filter_depth empties the ring.
module load_cell_sample_conditioner #(
    parameter int RING_SIZE = lcsc_pkg::RING_SIZE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lcsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lcsc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  lcsc_pkg::in_beat_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output lcsc_pkg::out_beat_t            out_data
);

    lcsc_pkg::cmd_t cmd;
    lcsc_pkg::sts_t sts;

    lcsc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_timed_out (in_data.timed_out),
        .in_ready     (in_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    lcsc_datapath #(
        .RING_SIZE (RING_SIZE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

[verif/load_cell_sample_conditioner_tb.sv]
// Self-checking bench for load_cell_sample_conditioner: a weight scoreboard
// predicts each result beat from the accepted samples. Needs lcsc_pkg and the RTL.
module load_cell_sample_conditioner_tb;
    import lcsc_pkg::*;

    localparam int RING = 16;

    // weight predictor and the queue of pending result beats
    class weight_scoreboard;
        logic signed [WGT_W-1:0] min_w, max_w;
        logic signed [RAW_W-1:0] min_r, max_r;
        logic signed [TARE_W-1:0] tare;
        logic [DEPTH_CFG_W-1:0] depth_reg;
        logic [THR_W-1:0] thresh;
        longint ring_vals[RING];
        int ring_pos;
        longint ring_total;
        longint cached, last_sent;
        out_beat_t pending[$];
        int errors;

        function void clear_ring();
            foreach (ring_vals[i]) ring_vals[i] = 0;
            ring_pos = 0;
            ring_total = 0;
        endfunction

        function void reset_state();
            min_w = 0; max_w = 256000; min_r = 0; max_r = 8388607;
            tare = 0; depth_reg = 1; thresh = 256;
            clear_ring();
            cached = 0; last_sent = 0; errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_MIN_WEIGHT: min_w = val;
                CFG_MAX_WEIGHT: max_w = val;
                CFG_MIN_RAW:    min_r = val[RAW_W-1:0];
                CFG_MAX_RAW:    max_r = val[RAW_W-1:0];
                CFG_TARE:       tare = val[TARE_W-1:0];
                CFG_DEPTH:
                begin
                    depth_reg = val[DEPTH_CFG_W-1:0];
                    clear_ring();
                end
                CFG_THRESHOLD:  thresh = val[THR_W-1:0];
                default: ;
            endcase
        endfunction

        function longint to_weight(longint mean);
            longint lo, hi, q, w;
            lo = min_r;
            hi = max_r;
            if (hi == lo) return 0;
            q = ((mean - lo) * (longint'(max_w) - longint'(min_w))) / (hi - lo);
            w = longint'(min_w) + q;
            if (w > 64'sd2147483647) w = 64'sd2147483647;
            if (w < -64'sd2147483648) w = -64'sd2147483648;
            return w;
        endfunction

        function void note_sample(in_beat_t b);
            out_beat_t r;
            int d, p;
            longint s, diff;
            r.notify = 0;
            r.read_error = 0;
            if (b.timed_out)
            begin
                r.read_error = 1;
            end
            else
            begin
                d = depth_reg;
                if (d < 1) d = 1;
                if (d > RING) d = RING;
                p = (ring_pos >= d) ? 0 : ring_pos;
                s = longint'($signed(b.raw_sample)) - longint'(tare);
                ring_total += s - ring_vals[p];
                ring_vals[p] = s;
                p++;
                ring_pos = (p >= d) ? 0 : p;
                cached = to_weight(ring_total / d);
                diff = cached - last_sent;
                if (diff < 0) diff = -diff;
                if (diff > longint'(thresh))
                begin
                    last_sent = cached;
                    r.notify = 1;
                end
            end
            r.weight = cached[31:0];
            pending.push_back(r);
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t e;
            if (pending.size() == 0)
            begin
                $error("result beat with nothing pending: weight %0d", got.weight);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.weight !== e.weight)
            begin
                $error("weight: expected %0d actual %0d", e.weight, got.weight);
                errors++;
            end
            if (got.notify !== e.notify)
            begin
                $error("notify: expected %0b actual %0b", e.notify, got.notify);
                errors++;
            end
            if (got.read_error !== e.read_error)
            begin
                $error("read_error: expected %0b actual %0b", e.read_error, got.read_error);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_ready;
    in_beat_t in_data = '0;
    logic out_valid;
    logic out_ready = 0;
    out_beat_t out_data;

    weight_scoreboard board = new();
    bit quiet = 0;   // no idling in the final stretch

    load_cell_sample_conditioner dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
        .out_data(out_data)
    );

    always #6 clk = ~clk;

    // receiver: random stall bursts, check on every accepted beat
    initial
    begin
        int burst;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 0;
                burst = $urandom_range(1, 7);
                repeat (burst) @(negedge clk);
            end
            out_ready <= 1;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready) board.check_result(out_data);

    // one sample beat: random gap, hold valid until taken
    task automatic send_sample(logic [SAMPLE_BITS-1:0] raw, logic tmo);
        in_beat_t b;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        b.raw_sample = raw;
        b.timed_out = tmo;
        in_valid <= 1;
        in_data <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_sample(b);
        @(negedge clk);
    endtask

    // wait for the block to drain, then a margin for its latency
    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (160) @(negedge clk);
    endtask

    // one register write, then the write port returns to idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        board.write_reg(idx, val);
        @(negedge clk);
        cfg_we <= 0;
        @(negedge clk);
    endtask

    task automatic random_setting(int phase);
        case (phase % 4)
            0:
            begin
                write_reg(CFG_MIN_WEIGHT, 32'h8000_0000);
                write_reg(CFG_MAX_WEIGHT, 32'h7fff_ffff);
                write_reg(CFG_MIN_RAW, 32'h1000000);
                write_reg(CFG_MAX_RAW, 32'h0ffffff);
            end
            1:
            begin
                write_reg(CFG_MIN_WEIGHT, $urandom());
                write_reg(CFG_MAX_WEIGHT, $urandom());
                write_reg(CFG_MIN_RAW, $urandom());
                write_reg(CFG_MAX_RAW, $urandom());
            end
            2:
            begin
                write_reg(CFG_MIN_WEIGHT, $urandom_range(0, 1000));
                write_reg(CFG_MAX_WEIGHT, 32'd256000 + $urandom_range(0, 1000));
                write_reg(CFG_MIN_RAW, -$urandom_range(0, 200000));
                write_reg(CFG_MAX_RAW, $urandom_range(1, 8388607));
            end
            default:
            begin
                write_reg(CFG_MIN_WEIGHT, $urandom());
                write_reg(CFG_MAX_WEIGHT, 32'h7fff_ffff);
                write_reg(CFG_MIN_RAW, 32'd5000);
                write_reg(CFG_MAX_RAW, 32'd5001);
            end
        endcase
        write_reg(CFG_TARE, (phase % 3 == 0) ? 32'h80_0000 : $urandom());
        write_reg(CFG_DEPTH, (phase % 5 == 0) ? 32'd31 : $urandom_range(0, 17));
        write_reg(CFG_THRESHOLD, (phase % 4 == 1) ? 32'h7fff_ffff : $urandom_range(0, 60000));
    endtask

    // main stimulus
    initial
    begin
        logic [SAMPLE_BITS-1:0] extremes[6] = '{24'h000000, 24'hffffff,
            24'h7fffff, 24'h800000, 24'h000001, 24'h555555};
        board.reset_state();
        repeat (2) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed: field extremes at reset settings, timeouts, depth 0 and 16
        foreach (extremes[i]) send_sample(extremes[i], 0);
        send_sample(24'hffffff, 1);
        send_sample(24'h000000, 1);
        drain();
        write_reg(CFG_DEPTH, 0);
        write_reg(CFG_THRESHOLD, 0);
        send_sample(24'h123456, 0);
        send_sample(24'h123456, 0);
        drain();
        write_reg(CFG_DEPTH, 16);
        write_reg(CFG_TARE, 32'h7f_ffff);
        write_reg(CFG_MIN_WEIGHT, 32'h8000_0000);
        write_reg(CFG_MAX_WEIGHT, 32'h7fff_ffff);
        write_reg(CFG_MIN_RAW, 32'h0ffffff);
        write_reg(CFG_MAX_RAW, 32'h1000000);
        foreach (extremes[i]) send_sample(extremes[i], 0);
        drain();
        write_reg(CFG_MAX_RAW, 32'h0ffffff);   // equal calibration raws
        write_reg(CFG_THRESHOLD, 32'h7fff_ffff);
        send_sample(24'h400000, 0);
        send_sample(24'h000000, 1);
        drain();

        // random phases under changing settings
        for (int ph = 0; ph < 14; ph++)
        begin
            random_setting(ph);
            if (ph == 13) quiet = 1;
            repeat (100) send_sample($urandom(), $urandom_range(0, 9) == 0);
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial
    begin
        #40000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

[filelist.f]
hw/rtl/lcsc_pkg.sv
hw/rtl/lcsc_ram.sv
hw/rtl/lcsc_div.sv
hw/rtl/lcsc_datapath.sv
hw/rtl/lcsc_ctrl.sv
hw/rtl/load_cell_sample_conditioner.sv
verif/load_cell_sample_conditioner_tb.sv
